// ===== hdl/lzwe_pkg.sv =====
// shared constants, types and the dictionary hash for the lzw encoder
// no dependencies
`timescale 1ns / 1ps

package lzwe_pkg;

	localparam int CODE_BITS    = 13;
	localparam int DICT_ENTRIES = 8192;
	localparam int CODE_SPACE   = 1 << CODE_BITS;
	localparam int CODE_LIMIT   = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
	localparam int CIDX_BITS    = $clog2(CODE_LIMIT);
	localparam int NC_BITS      = CODE_BITS + 1;
	localparam int HASH_BITS    = CODE_BITS + 1;
	localparam int SLOTS        = 1 << HASH_BITS;
	localparam int KEY_BITS     = CODE_BITS + 8;
	localparam int STORE_BITS   = CODE_BITS + 7;
	localparam int CNT_BITS     = $clog2(STORE_BITS + 1);
	localparam int FIRST_CODE   = 256;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [CODE_BITS-1:0] code;
		logic                 last;
	} code_t;

	typedef struct packed {
		logic [KEY_BITS-1:0]  key;
		logic [CODE_BITS-1:0] code;
	} slot_t;

	function automatic logic [HASH_BITS-1:0] dict_hash(input logic [CODE_BITS-1:0] prefix,
		input logic [7:0] data);
		logic [HASH_BITS-1:0] p;
		logic [HASH_BITS-1:0] d;
		p = HASH_BITS'(prefix);
		d = HASH_BITS'(data) << (HASH_BITS - 8);
		return p ^ d;
	endfunction

endpackage

// ===== hdl/lzwe_front.sv =====
// input side: takes bytes from the push/full port into a short request queue
// depends on lzwe_pkg
`timescale 1ns / 1ps

module lzwe_front import lzwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	input  logic       push,
	output logic       full,
	output logic       item_valid,
	output item_t      item,
	input  logic       item_pop
);

	item_t      q_q [4];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       do_push;
	logic       do_pop;

	assign full       = (cnt_q == 3'd4);
	assign item_valid = (cnt_q != 3'd0);
	assign item       = q_q[rd_q];
	assign do_push    = push && !full;
	assign do_pop     = item_pop && item_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			q_q[wr_q].data <= in_byte;
			q_q[wr_q].last <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) wr_q <= wr_q + 2'd1;
			if (do_pop) rd_q <= rd_q + 2'd1;
			if (do_push && !do_pop) cnt_q <= cnt_q + 3'd1;
			else if (!do_push && do_pop) cnt_q <= cnt_q - 3'd1;
		end
	end

endmodule

// ===== hdl/lzwe_dict.sv =====
// dictionary engine: hashed lookup with linear probing, insert, code emission
// depends on lzwe_pkg
// after reset one pass over all slots clears the slot table before any request is taken
`timescale 1ns / 1ps

module lzwe_dict import lzwe_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  item_valid,
	input  item_t item,
	output logic  item_pop,
	output logic  code_push,
	output code_t code,
	input  logic  code_full
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_PROBE = 3'd1;
	localparam logic [2:0] S_CHK1  = 3'd2;
	localparam logic [2:0] S_CHK2  = 3'd3;
	localparam logic [2:0] S_EMITA = 3'd4;
	localparam logic [2:0] S_EMITL = 3'd5;
	localparam logic [2:0] S_CLEAR = 3'd6;

	slot_t                slot_mem  [SLOTS];
	logic [HASH_BITS-1:0] code_slot [CODE_LIMIT];

	logic [2:0]           state_q;
	logic [HASH_BITS-1:0] clr_q;
	logic [NC_BITS-1:0]   next_code_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 have_q;
	logic                 last_q;
	logic [7:0]           byte_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [HASH_BITS-1:0] slot_q;
	logic [CODE_BITS-1:0] emit_code_q;
	slot_t                sm_rd_q;
	logic [HASH_BITS-1:0] cs_rd_q;

	logic live;
	logic valid_slot;
	logic hit;
	logic room;

	assign live       = ({1'b0, sm_rd_q.code} >= NC_BITS'(FIRST_CODE))
		&& ({1'b0, sm_rd_q.code} < next_code_q);
	assign valid_slot = live && (cs_rd_q == slot_q);
	assign hit        = valid_slot && (sm_rd_q.key == key_q);
	assign room       = next_code_q < NC_BITS'(CODE_LIMIT);

	assign item_pop  = (state_q == S_IDLE) && item_valid;
	assign code_push = ((state_q == S_EMITA) || (state_q == S_EMITL)) && !code_full;
	always_comb begin
		code.code = (state_q == S_EMITA) ? emit_code_q : prefix_q;
		code.last = (state_q == S_EMITL);
	end

	// lookup memories, registered reads
	always_ff @(posedge clk) begin
		if (state_q == S_PROBE) sm_rd_q <= slot_mem[slot_q];
		if (state_q == S_CHK1) cs_rd_q <= code_slot[sm_rd_q.code[CIDX_BITS-1:0]];
		if (state_q == S_CLEAR) begin
			slot_mem[clr_q] <= '0;
		end else if ((state_q == S_CHK2) && !valid_slot && room) begin
			slot_mem[slot_q].key  <= key_q;
			slot_mem[slot_q].code <= next_code_q[CODE_BITS-1:0];
			code_slot[next_code_q[CIDX_BITS-1:0]] <= slot_q;
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			byte_q <= item.data;
			key_q  <= {prefix_q, item.data};
			slot_q <= dict_hash(prefix_q, item.data);
		end else if ((state_q == S_CHK2) && valid_slot && !hit) begin
			slot_q <= slot_q + HASH_BITS'(1);
		end
		if ((state_q == S_CHK2) && !hit) emit_code_q <= prefix_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			next_code_q <= NC_BITS'(FIRST_CODE);
			prefix_q    <= '0;
			have_q      <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + HASH_BITS'(1);
					if (clr_q == '1) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (item_valid) begin
						last_q <= item.last;
						if (!have_q) begin
							prefix_q <= CODE_BITS'(item.data);
							have_q   <= 1'b1;
							state_q  <= item.last ? S_EMITL : S_IDLE;
						end else begin
							state_q <= S_PROBE;
						end
					end
				end
				S_PROBE: state_q <= S_CHK1;
				S_CHK1:  state_q <= S_CHK2;
				S_CHK2: begin
					if (hit) begin
						prefix_q <= sm_rd_q.code;
						state_q  <= last_q ? S_EMITL : S_IDLE;
					end else if (valid_slot) begin
						state_q <= S_PROBE;
					end else begin
						if (room) next_code_q <= next_code_q + NC_BITS'(1);
						prefix_q <= CODE_BITS'(byte_q);
						state_q  <= S_EMITA;
					end
				end
				S_EMITA: begin
					if (!code_full) state_q <= last_q ? S_EMITL : S_IDLE;
				end
				S_EMITL: begin
					if (!code_full) begin
						next_code_q <= NC_BITS'(FIRST_CODE);
						prefix_q    <= '0;
						have_q      <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== hdl/lzwe_pack.sv =====
// back end: code queue, msb-first bit packer and output byte register
// depends on lzwe_pkg
`timescale 1ns / 1ps

module lzwe_pack import lzwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       code_push,
	input  code_t      code,
	output logic       code_full,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       empty,
	input  logic       pop
);

	code_t                 q_q [4];
	logic [1:0]            wr_q;
	logic [1:0]            rd_q;
	logic [2:0]            qcnt_q;
	logic [STORE_BITS-1:0] store_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic                  flush_q;
	logic                  ov_q;
	logic [7:0]            ob_q;
	logic                  ol_q;

	logic                  slot_free;
	logic                  q_valid;
	logic                  do_full;
	logic                  do_pad;
	logic                  do_take;
	logic                  q_pop;
	logic [CNT_BITS-1:0]   cnt_m8;
	logic [STORE_BITS-1:0] shr;
	logic [6:0]            low_mask;
	logic [STORE_BITS+7:0] pad_w;

	assign code_full = (qcnt_q == 3'd4);
	assign q_valid   = (qcnt_q != 3'd0);
	assign slot_free = !ov_q || pop;
	assign do_full   = slot_free && (cnt_q >= CNT_BITS'(8));
	assign do_pad    = slot_free && !do_full && flush_q && (cnt_q != '0);
	assign do_take   = !flush_q && (cnt_q < CNT_BITS'(8)) && q_valid;
	assign q_pop     = do_take;
	assign cnt_m8    = cnt_q - CNT_BITS'(8);
	assign shr       = store_q >> cnt_m8;
	assign low_mask  = 7'((8'd1 << cnt_q[2:0]) - 8'd1);
	assign pad_w     = (STORE_BITS+8)'(store_q) << (4'd8 - 4'(cnt_q[2:0]));

	assign empty    = !ov_q;
	assign out_byte = ob_q;
	assign out_last = ol_q;

	always_ff @(posedge clk) begin
		if (code_push && !code_full) q_q[wr_q] <= code;
		if (do_full) begin
			ob_q <= shr[7:0];
			ol_q <= flush_q && (cnt_m8 == '0);
		end else if (do_pad) begin
			ob_q <= pad_w[7:0];
			ol_q <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			qcnt_q  <= '0;
			store_q <= '0;
			cnt_q   <= '0;
			flush_q <= 1'b0;
			ov_q    <= 1'b0;
		end else begin
			if (code_push && !code_full) wr_q <= wr_q + 2'd1;
			if (q_pop) rd_q <= rd_q + 2'd1;
			if ((code_push && !code_full) && !q_pop) qcnt_q <= qcnt_q + 3'd1;
			else if (!(code_push && !code_full) && q_pop) qcnt_q <= qcnt_q - 3'd1;

			if (do_full) begin
				cnt_q <= cnt_m8;
			end else if (do_pad) begin
				cnt_q <= '0;
			end else if (do_take) begin
				store_q <= {store_q[6:0] & low_mask, q_q[rd_q].code};
				cnt_q   <= cnt_q + CNT_BITS'(CODE_BITS);
				flush_q <= q_q[rd_q].last;
			end
			// block ends once all its bits have left
			if (flush_q && (do_pad || (do_full && (cnt_m8 == '0)))) begin
				flush_q <= 1'b0;
				store_q <= '0;
			end

			if (do_full || do_pad) ov_q <= 1'b1;
			else if (pop) ov_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/lzw_encoder_13bit_packed.sv =====
// lzw encoder, 13-bit codes packed msb first into bytes, top level
// a byte passes the front queue to the dictionary engine, which takes it when idle and
// probes through the probe, chk1 and chk2 states, again for each extra probe; a code is sent
// when the match ends; the engine takes no new byte until it is done with the last one
// the first byte of a block starts a match, the last also sends the final code; reset clears
// control state, then a pass clears the slot table; bytes wait in the queue until it is done
`timescale 1ns / 1ps

module lzw_encoder_13bit_packed import lzwe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] in_byte,
	input  logic       is_last,
	input  logic       push,
	output logic       full,
	output logic [7:0] out_byte,
	output logic       out_last,
	output logic       empty,
	input  logic       pop
);

	logic  item_valid;
	item_t item;
	logic  item_pop;
	logic  code_push;
	code_t code;
	logic  code_full;

	lzwe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_byte    (in_byte),
		.is_last    (is_last),
		.push       (push),
		.full       (full),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop)
	);

	lzwe_dict u_dict (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.item_pop   (item_pop),
		.code_push  (code_push),
		.code       (code),
		.code_full  (code_full)
	);

	lzwe_pack u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.code_push (code_push),
		.code      (code),
		.code_full (code_full),
		.out_byte  (out_byte),
		.out_last  (out_last),
		.empty     (empty),
		.pop       (pop)
	);

endmodule
